// ===== hw/rtl/nsr_pkg.sv =====
// ----------------------------------------------------------------------------
// nsr_pkg: shared definitions for the Newton square root unit
// Widths, iteration limits, register map and sequencer states.
// ----------------------------------------------------------------------------
package nsr_pkg;

	// Fixed-point format and iteration limit.
	localparam int FRAC_BITS = 16;
	localparam int MAX_STEPS = 64;

	// Word widths set by the fixed port widths.
	localparam int WORD_W = 32;
	localparam int STEP_W = 7;
	localparam int NUM_W  = WORD_W + FRAC_BITS;
	localparam int CNT_W  = $clog2(NUM_W);

	// Initial guess of 1.0 and the step cap as sized values.
	localparam logic [WORD_W-1:0] GUESS_ONE = WORD_W'(1) << FRAC_BITS;
	localparam logic [STEP_W-1:0] STEP_CAP  = STEP_W'(MAX_STEPS);

	// Configuration register map.
	localparam int ADDR_W = 3;
	localparam logic REG_TOLERANCE = 1'b0;
	localparam logic [WORD_W-1:0] TOLERANCE_RESET = 32'd1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_DIV,
		ST_ADD,
		ST_CHECK,
		ST_OUT
	} state_t;

	// Status of the shared divider as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ===== hw/rtl/newton_square_root_unit.sv =====
// ----------------------------------------------------------------------------
// newton_square_root_unit: fixed-point square root by Newton iteration
// Sequencer around one shared divider, plus the tolerance register.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy then stays high
// until the result has been shown. Each Newton step passes through the test,
// divide, add and compare states; in the divide state the bit-serial divider
// forms one quotient bit per cycle over the 48-bit scaled radicand and then
// hands the quotient back. The next word is taken only after the result has
// been shown and the unit is idle again. The result is shown on root,
// steps_taken and not_converged for exactly one cycle with done high; the
// receiver cannot stall, so it must capture the word in that cycle.
// ----------------------------------------------------------------------------
module newton_square_root_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [nsr_pkg::WORD_W-1:0]    radicand,
	output logic                          done,
	output logic [nsr_pkg::WORD_W-1:0]    root,
	output logic [nsr_pkg::STEP_W-1:0]    steps_taken,
	output logic                          not_converged,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nsr_pkg::ADDR_W-1:0]    paddr,
	input  logic [nsr_pkg::WORD_W-1:0]    pwdata,
	output logic [nsr_pkg::WORD_W-1:0]    prdata,
	output logic                          pready
);

	nsr_pkg::state_t              state_q, state_d;
	logic [nsr_pkg::NUM_W-1:0]    num_q;
	logic [nsr_pkg::WORD_W-1:0]   y_q;
	logic [nsr_pkg::WORD_W-1:0]   y_next_q;
	logic [nsr_pkg::STEP_W-1:0]   steps_q;
	logic                         flag_q;
	logic [nsr_pkg::WORD_W-1:0]   tolerance;
	logic [nsr_pkg::NUM_W-1:0]    quotient;
	nsr_pkg::div_status_t         div_status;
	logic                         div_start;
	logic                         accept;
	logic                         at_cap;
	logic                         y_zero;
	logic [nsr_pkg::NUM_W:0]      sum;
	logic [nsr_pkg::NUM_W-1:0]    half;
	logic [nsr_pkg::WORD_W-1:0]   delta;
	logic                         converged;

	nsr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.tolerance (tolerance)
	);

	nsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_q),
		.divisor  (y_q),
		.quotient (quotient),
		.status   (div_status)
	);

	// Step tests, the averaged guess and the step change.
	always_comb begin
		accept    = start && !busy;
		at_cap    = (steps_q >= nsr_pkg::STEP_CAP);
		y_zero    = (y_q == '0);
		sum       = {{(nsr_pkg::NUM_W + 1 - nsr_pkg::WORD_W){1'b0}}, y_q} + {1'b0, quotient};
		half      = sum[nsr_pkg::NUM_W:1];
		delta     = (y_next_q >= y_q) ? (y_next_q - y_q) : (y_q - y_next_q);
		converged = (delta <= tolerance);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			nsr_pkg::ST_IDLE: begin
				if (start) state_d = nsr_pkg::ST_TEST;
			end
			nsr_pkg::ST_TEST: begin
				if (at_cap || y_zero) state_d = nsr_pkg::ST_OUT;
				else state_d = nsr_pkg::ST_DIV;
			end
			nsr_pkg::ST_DIV: begin
				if (div_status.done) state_d = nsr_pkg::ST_ADD;
			end
			nsr_pkg::ST_ADD:   state_d = nsr_pkg::ST_CHECK;
			nsr_pkg::ST_CHECK: begin
				if (converged) state_d = nsr_pkg::ST_OUT;
				else state_d = nsr_pkg::ST_TEST;
			end
			nsr_pkg::ST_OUT:   state_d = nsr_pkg::ST_IDLE;
			default:           state_d = nsr_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		busy      = 1'b1;
		done      = 1'b0;
		div_start = 1'b0;
		case (state_q)
			nsr_pkg::ST_IDLE: busy = 1'b0;
			nsr_pkg::ST_TEST: div_start = !(at_cap || y_zero);
			nsr_pkg::ST_OUT:  done = 1'b1;
			default:          ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nsr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers, loaded on acceptance and updated once per step.
	always_ff @(posedge clk) begin
		if (accept) begin
			num_q   <= {radicand, {nsr_pkg::FRAC_BITS{1'b0}}};
			y_q     <= nsr_pkg::GUESS_ONE;
			steps_q <= '0;
			flag_q  <= 1'b0;
		end else begin
			case (state_q)
				nsr_pkg::ST_TEST: begin
					if (at_cap) flag_q <= 1'b1;
				end
				nsr_pkg::ST_ADD: begin
					if (half[nsr_pkg::NUM_W-1:nsr_pkg::WORD_W] != '0) y_next_q <= '1;
					else y_next_q <= half[nsr_pkg::WORD_W-1:0];
				end
				nsr_pkg::ST_CHECK: begin
					y_q     <= y_next_q;
					steps_q <= steps_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign root          = y_q;
	assign steps_taken   = steps_q;
	assign not_converged = flag_q;

endmodule

// ===== hw/rtl/nsr_div.sv =====
// ----------------------------------------------------------------------------
// nsr_div: shared restoring divider
// Divides a NUM_W-bit dividend by a 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nsr_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [nsr_pkg::NUM_W-1:0]        dividend,
	input  logic [nsr_pkg::WORD_W-1:0]       divisor,
	output logic [nsr_pkg::NUM_W-1:0]        quotient,
	output nsr_pkg::div_status_t             status
);

	logic                          busy_q;
	logic                          done_q;
	logic [nsr_pkg::CNT_W-1:0]     cnt_q;
	logic [nsr_pkg::WORD_W-1:0]    rem_q;
	logic [nsr_pkg::NUM_W-1:0]     dq_q;
	logic [nsr_pkg::WORD_W-1:0]    divisor_q;
	logic [nsr_pkg::WORD_W:0]      trial;
	logic [nsr_pkg::WORD_W:0]      diff;
	logic                          ge;

	// Trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		trial = {rem_q, dq_q[nsr_pkg::NUM_W-1]};
		diff  = trial - {1'b0, divisor_q};
		ge    = (trial >= {1'b0, divisor_q});
	end

	// Control of the iteration count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nsr_pkg::CNT_W'(nsr_pkg::NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register; the dividend shifts out as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			dq_q      <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[nsr_pkg::WORD_W-1:0] : trial[nsr_pkg::WORD_W-1:0];
			dq_q  <= {dq_q[nsr_pkg::NUM_W-2:0], ge};
		end
	end

	assign quotient    = dq_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

// ===== hw/rtl/nsr_cfg.sv =====
// ----------------------------------------------------------------------------
// nsr_cfg: configuration registers
// APB-style slave holding the convergence tolerance.
// ----------------------------------------------------------------------------
module nsr_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nsr_pkg::ADDR_W-1:0]    paddr,
	input  logic [nsr_pkg::WORD_W-1:0]    pwdata,
	output logic [nsr_pkg::WORD_W-1:0]    prdata,
	output logic                          pready,
	output logic [nsr_pkg::WORD_W-1:0]    tolerance
);

	logic [nsr_pkg::WORD_W-1:0] tolerance_q;
	logic                       reg_index;
	logic                       wr_en;

	// Word address decode; the byte offset bits are ignored.
	assign reg_index = paddr[nsr_pkg::ADDR_W-1];
	assign wr_en     = psel && penable && pwrite && (reg_index == nsr_pkg::REG_TOLERANCE);

	// Tolerance register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= nsr_pkg::TOLERANCE_RESET;
		end else if (wr_en) begin
			tolerance_q <= pwdata;
		end
	end

	// Read data; unmapped words read as zero.
	always_comb begin
		case (reg_index)
			nsr_pkg::REG_TOLERANCE: prdata = tolerance_q;
			default:                prdata = '0;
		endcase
	end

	assign pready    = 1'b1;
	assign tolerance = tolerance_q;

endmodule

// ===== hw/rtl/nsr_checker.sv =====
// ----------------------------------------------------------------------------
// nsr_checker: port-level checks for the Newton square root unit
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module nsr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [nsr_pkg::STEP_W-1:0]    steps_taken,
	input logic                          not_converged
);

	// A taken word makes the unit busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("unit not busy after a word was taken");

	// A result is only shown while the unit is still busy with its word.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown while idle");

	// Each word gives one result, a single-cycle strobe followed by idle.
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	// The step count never exceeds the cap.
	a_steps_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> steps_taken <= nsr_pkg::STEP_CAP)
		else $error("step count above cap");

	// The flag is raised only when the cap was reached.
	a_flag_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done && not_converged |-> steps_taken == nsr_pkg::STEP_CAP)
		else $error("not_converged without reaching the cap");

endmodule

bind newton_square_root_unit nsr_checker u_nsr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.steps_taken   (steps_taken),
	.not_converged (not_converged)
);

// ===== tb/newton_square_root_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_square_root_unit_tb: self-checking bench for the Newton square root
// Directed radicands and tolerances from a table run first, then random words
// in several tolerance phases. Each root word is compared with its table row's
// typed result, if any, else with a bit-exact model of the fixed-point Heron
// iteration. The tolerance register is read back over APB after every write.
// ----------------------------------------------------------------------------
module newton_square_root_unit_tb;
	import nsr_pkg::*;

	// Register addresses on the APB port; the spare slot decodes to no register.
	localparam logic [ADDR_W-1:0] TOL_ADDR   = ADDR_W'(4 * REG_TOLERANCE);
	localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4);
	localparam logic [WORD_W-1:0] TOL_MAX    = '1;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_WORDS   = 100;
	localparam int MAX_REPORTS   = 10;

	// One root word as the block returns it.
	typedef struct packed {
		logic [WORD_W-1:0] root;
		logic [STEP_W-1:0] steps;
		logic              capped;
	} sqrt_result_t;

	// One row of the directed table.
	typedef struct packed {
		logic [WORD_W-1:0] tol;
		logic [WORD_W-1:0] rad;
		logic              typed;
		sqrt_result_t      want;
	} trial_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [WORD_W-1:0]   radicand = '0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [WORD_W-1:0]   pwdata = '0;
	logic                busy;
	logic                done;
	logic [WORD_W-1:0]   root;
	logic [STEP_W-1:0]   steps_taken;
	logic                not_converged;
	logic [WORD_W-1:0]   prdata;
	logic                pready;

	sqrt_result_t pending_roots[$];
	logic [WORD_W-1:0] tol_model = TOLERANCE_RESET;
	bit idle_on = 1'b1;
	int mismatch_count = 0;
	int words_sent = 0;
	int roots_seen = 0;
	int capped_seen = 0;
	int zero_seen = 0;
	int tol_writes = 0;

	localparam sqrt_result_t NO_TYPED = '0;

	// Directed rows: extremes, the zero-guess guard and the iteration cap.
	trial_t trial_table [20] = '{
		'{TOLERANCE_RESET, GUESS_ONE,    1'b1, '{GUESS_ONE, 7'd1, 1'b0}},
		'{TOLERANCE_RESET, 32'h00000000, 1'b0, NO_TYPED},
		'{TOLERANCE_RESET, 32'hFFFFFFFF, 1'b0, NO_TYPED},
		'{TOLERANCE_RESET, 32'h00040000, 1'b0, NO_TYPED},
		'{TOLERANCE_RESET, 32'h00000001, 1'b0, NO_TYPED},
		'{TOLERANCE_RESET, 32'h80000000, 1'b0, NO_TYPED},
		'{TOLERANCE_RESET, 32'h00020000, 1'b0, NO_TYPED},
		'{32'h00000000,    32'h00000000, 1'b1, '{32'h00000000, 7'd17, 1'b0}},
		'{32'h00000000,    32'h0000FFFE, 1'b1, '{32'h0000FFFE, STEP_CAP, 1'b1}},
		'{32'h00000000,    32'hFFFFFFFF, 1'b0, NO_TYPED},
		'{32'h00000000,    32'h00090000, 1'b0, NO_TYPED},
		'{32'h00000000,    32'h00000001, 1'b0, NO_TYPED},
		'{TOL_MAX,         32'h00000000, 1'b1, '{32'h00008000, 7'd1, 1'b0}},
		'{TOL_MAX,         32'hFFFFFFFF, 1'b1, '{32'h80007FFF, 7'd1, 1'b0}},
		'{TOL_MAX,         GUESS_ONE,    1'b1, '{GUESS_ONE, 7'd1, 1'b0}},
		'{32'h00010000,    32'h00640000, 1'b0, NO_TYPED},
		'{32'h00010000,    32'h12345678, 1'b0, NO_TYPED},
		'{32'hA5A5A5A5,    32'h5A5A5A5A, 1'b0, NO_TYPED},
		'{32'h5A5A5A5A,    32'hA5A5A5A5, 1'b0, NO_TYPED},
		'{TOLERANCE_RESET, 32'h00000002, 1'b0, NO_TYPED}
	};

	newton_square_root_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.radicand      (radicand),
		.done          (done),
		.root          (root),
		.steps_taken   (steps_taken),
		.not_converged (not_converged),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Heron iteration on the scaled radicand, with the zero-guess guard,
	// saturation of the new guess and the step cap.
	function automatic sqrt_result_t heron_root(input logic [WORD_W-1:0] x,
			input logic [WORD_W-1:0] tol);
		logic [63:0] num;
		logic [63:0] guess;
		logic [63:0] prev;
		logic [63:0] diff;
		int unsigned count;
		bit stop;
		sqrt_result_t res;
		num = {32'b0, x} << FRAC_BITS;
		guess = 64'(GUESS_ONE);
		count = 0;
		stop = 1'b0;
		res = '0;
		while (!stop) begin
			if (count >= MAX_STEPS) begin
				res.capped = 1'b1;
				stop = 1'b1;
			end else if (guess == 64'd0) begin
				stop = 1'b1;
			end else begin
				prev = guess;
				guess = (prev + num / prev) >> 1;
				if (guess > 64'h00000000FFFFFFFF)
					guess = 64'h00000000FFFFFFFF;
				count++;
				diff = (guess >= prev) ? guess - prev : prev - guess;
				if (diff <= {32'b0, tol})
					stop = 1'b1;
			end
		end
		res.root = guess[WORD_W-1:0];
		res.steps = STEP_W'(count);
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("[%0t] MISMATCH %s", $realtime, msg);
	endtask

	task automatic check_field(input string what, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (got !== want)
			report_mismatch($sformatf("%s: expected %h, got %h", what, want, got));
	endtask

	// APB write: setup cycle, then access until pready.
	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == TOL_ADDR)
			tol_model = data;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// APB read of the tolerance register, compared with the model copy.
	task automatic check_tolerance_readback();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= TOL_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("tolerance readback", tol_model, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Lower start and wait until every root word has come and the block is idle.
	task automatic drain_roots();
		start <= 1'b0;
		do @(posedge clk); while (pending_roots.size() != 0 || busy);
	endtask

	task automatic set_tolerance(input logic [WORD_W-1:0] tol);
		drain_roots();
		apb_write(TOL_ADDR, tol);
		tol_writes++;
		check_tolerance_readback();
	endtask

	// Present one radicand; start stays high afterwards so back-to-back words
	// never lower and raise it in the same step.
	task automatic send_radicand(input logic [WORD_W-1:0] value, input logic typed,
			input sqrt_result_t typed_want);
		int gap;
		if (idle_on && $urandom_range(0, 99) < 6) begin
			gap = $urandom_range(1, 300);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		radicand <= value;
		do @(posedge clk); while (busy);
		pending_roots.push_back(typed ? typed_want : heron_root(value, tol_model));
		words_sent++;
	endtask

	// Mix of full-range words, small values below 4.0, near squares and corner values.
	function automatic logic [WORD_W-1:0] pick_radicand();
		int unsigned pick;
		logic [31:0] k;
		pick = $urandom_range(0, 99);
		k = $urandom_range(0, 65535);
		if (pick < 35)
			return $urandom;
		else if (pick < 60)
			return $urandom_range(0, 32'h0003FFFF);
		else if (pick < 75)
			return k * k + $urandom_range(0, 2) - 1;
		else if (pick < 88)
			return (32'h1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
		case ($urandom_range(0, 4))
			0: return 32'h00000000;
			1: return 32'hFFFFFFFF;
			2: return 32'h00000001;
			3: return 32'h0000FFFE;
			default: return GUESS_ONE;
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] phase_tolerance(input int phase);
		case (phase)
			0: return TOLERANCE_RESET;
			1: return '0;
			2: return TOL_MAX;
			3: return $urandom_range(0, 255);
			4: return $urandom;
			5: return $urandom_range(0, 32'h0000FFFF);
			6: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// Check each root word against the oldest expectation.
	always @(posedge clk) begin
		sqrt_result_t want;
		if (arst_n && done) begin
			roots_seen++;
			if (not_converged)
				capped_seen++;
			if (root == '0)
				zero_seen++;
			if (pending_roots.size() == 0) begin
				report_mismatch($sformatf("unexpected root word %h steps %0d flag %b",
					root, steps_taken, not_converged));
			end else begin
				want = pending_roots.pop_front();
				check_field("root", want.root, root);
				check_field("steps_taken", WORD_W'(want.steps), WORD_W'(steps_taken));
				check_field("not_converged", WORD_W'(want.capped), WORD_W'(not_converged));
			end
		end
	end

	// Main sequence: reset, directed table, unmapped write, random phases, then the verdict.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_tolerance_readback();

		foreach (trial_table[i]) begin
			if (trial_table[i].tol != tol_model)
				set_tolerance(trial_table[i].tol);
			send_radicand(trial_table[i].rad, trial_table[i].typed, trial_table[i].want);
		end

		// A write to an unmapped slot must leave the tolerance alone.
		drain_roots();
		apb_write(SPARE_ADDR, 32'hDEADBEEF);
		check_tolerance_readback();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			set_tolerance(phase_tolerance(phase));
			idle_on = (phase != 3);
			for (int n = 0; n < PHASE_WORDS; n++)
				send_radicand(pick_radicand(), 1'b0, NO_TYPED);
		end

		drain_roots();
		repeat (200) @(posedge clk);

		$display("Sent %0d radicands over %0d tolerance settings; %0d roots checked,",
			words_sent, tol_writes + 1, roots_seen);
		$display("%0d of them at the iteration cap and %0d equal to zero.",
			capped_seen, zero_seen);
		if (mismatch_count == 0 && pending_roots.size() == 0) begin
			$display("newton_square_root_unit_tb OK");
		end else begin
			$display("%0d mismatches, %0d root words missing",
				mismatch_count, pending_roots.size());
			$display("newton_square_root_unit_tb NOT OK");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#100_000_000;
		$display("Timeout with %0d root words outstanding", pending_roots.size());
		$display("newton_square_root_unit_tb NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/nsr_pkg.sv
hw/rtl/nsr_div.sv
hw/rtl/nsr_cfg.sv
hw/rtl/newton_square_root_unit.sv
hw/rtl/nsr_checker.sv
tb/newton_square_root_unit_tb.sv
